@@ hw/rtl/assert_macros.svh @@
// ----------------------------------------------------------------------------
// assert_macros.svh
// Assertion shorthands used by the parser RTL of the serial frame receiver.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check that a condition holds at every clock edge out of reset.
`define ASSERT_ALWAYS(label, clk, rst_n, cond, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (cond)) else $error(msg);

// Check that a condition implies another in the same cycle.
`define ASSERT_IMPLIES(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error(msg);

// Check that a condition implies another in the next cycle.
`define ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

@@ hw/rtl/sfr_pkg.sv @@
// ----------------------------------------------------------------------------
// sfr_pkg
// Types and constants shared by the serial frame receiver modules.
// ----------------------------------------------------------------------------
package sfr_pkg;

	// Configuration port widths
	localparam int CFG_IDX_W  = 8;
	localparam int CFG_DATA_W = 32;

	// Configuration register indexes
	localparam logic [CFG_IDX_W-1:0] CFG_START_BYTE = 8'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_MAX_LEN    = 8'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_CRC_POLY   = 8'd2;
	localparam logic [CFG_IDX_W-1:0] CFG_CRC_START  = 8'd3;

	// Configuration reset values
	localparam logic [7:0]  START_BYTE_RST = 8'hA5;
	localparam logic [15:0] MAX_LEN_RST    = 16'd1024;
	localparam logic [31:0] CRC_POLY_RST   = 32'hEDB8_8320;
	localparam logic [31:0] CRC_START_RST  = 32'hFFFF_FFFF;

	// Parser steps
	typedef enum logic [1:0] {
		STEP_HUNT   = 2'd0,
		STEP_LEN_LO = 2'd1,
		STEP_LEN_HI = 2'd2,
		STEP_DATA   = 2'd3
	} step_t;

	// Current configuration
	typedef struct packed {
		logic [7:0]  start_byte;
		logic [15:0] max_frame_len;
		logic [31:0] crc_poly;
		logic [31:0] crc_start;
	} cfg_t;

	// One result transaction
	typedef struct packed {
		logic [7:0]  byte_value;
		logic        stored;
		logic [15:0] position;
		logic        frame_done;
		logic        crc_ok;
		logic [15:0] frame_length;
	} result_t;

endpackage

@@ hw/rtl/sfr_cfg_regs.sv @@
// ----------------------------------------------------------------------------
// sfr_cfg_regs
// Configuration register file written through the configuration port.
// ----------------------------------------------------------------------------
module sfr_cfg_regs (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           wr_en,
	input  logic [sfr_pkg::CFG_IDX_W-1:0]  wr_index,
	input  logic [sfr_pkg::CFG_DATA_W-1:0] wr_data,
	output sfr_pkg::cfg_t                  cfg
);

	sfr_pkg::cfg_t cfg_q;

	// Update the addressed register; ignore indexes beyond the list
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.start_byte    <= sfr_pkg::START_BYTE_RST;
			cfg_q.max_frame_len <= sfr_pkg::MAX_LEN_RST;
			cfg_q.crc_poly      <= sfr_pkg::CRC_POLY_RST;
			cfg_q.crc_start     <= sfr_pkg::CRC_START_RST;
		end else if (wr_en) begin
			case (wr_index)
				sfr_pkg::CFG_START_BYTE: cfg_q.start_byte    <= wr_data[7:0];
				sfr_pkg::CFG_MAX_LEN:    cfg_q.max_frame_len <= wr_data[15:0];
				sfr_pkg::CFG_CRC_POLY:   cfg_q.crc_poly      <= wr_data;
				sfr_pkg::CFG_CRC_START:  cfg_q.crc_start     <= wr_data;
				default: ;
			endcase
		end
	end

	assign cfg = cfg_q;

endmodule

@@ hw/rtl/sfr_crc_byte.sv @@
// ----------------------------------------------------------------------------
// sfr_crc_byte
// One-byte update of a reflected CRC-32 with a programmable polynomial.
// ----------------------------------------------------------------------------
module sfr_crc_byte (
	input  logic [31:0] crc_in,
	input  logic [7:0]  data,
	input  logic [31:0] poly,
	output logic [31:0] crc_out
);

	// Build the table entry bit by bit, then fold it into the shifted CRC
	always_comb begin
		logic [31:0] t;
		t = {24'd0, crc_in[7:0] ^ data};
		for (int k = 0; k < 8; k++) begin
			t = t[0] ? ((t >> 1) ^ poly) : (t >> 1);
		end
		crc_out = (crc_in >> 8) ^ t;
	end

endmodule

@@ hw/rtl/sfr_parser.sv @@
// ----------------------------------------------------------------------------
// sfr_parser
// Frame parser state machine: start hunt, length, data count and CRC check.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module sfr_parser (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             advance,
	input  logic [7:0]       rx_byte,
	input  sfr_pkg::cfg_t    cfg,
	output sfr_pkg::result_t res
);

	sfr_pkg::step_t step_q, step_d;
	logic [15:0]    len_q, len_d;
	logic [15:0]    idx_q, idx_d;
	logic [31:0]    crc_q, crc_d;

	logic [31:0] crc_seed;
	logic [31:0] crc_new;
	logic [15:0] idx_inc;
	logic [15:0] len_full;

	// Seed the CRC from the start value on the start byte
	assign crc_seed = (step_q == sfr_pkg::STEP_HUNT) ? cfg.crc_start : crc_q;
	assign idx_inc  = idx_q + 16'd1;
	assign len_full = {rx_byte, len_q[7:0]};

	sfr_crc_byte u_crc (
		.crc_in  (crc_seed),
		.data    (rx_byte),
		.poly    (cfg.crc_poly),
		.crc_out (crc_new)
	);

	// Hold parser state; advance one transaction at a time
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			step_q <= sfr_pkg::STEP_HUNT;
			len_q  <= 16'd0;
			idx_q  <= 16'd0;
			crc_q  <= sfr_pkg::CRC_START_RST;
		end else if (advance) begin
			step_q <= step_d;
			len_q  <= len_d;
			idx_q  <= idx_d;
			crc_q  <= crc_d;
		end
	end

	// Next state and result
	always_comb begin
		step_d           = step_q;
		len_d            = len_q;
		idx_d            = idx_q;
		crc_d            = crc_q;
		res.byte_value   = rx_byte;
		res.stored       = 1'b0;
		res.position     = 16'd0;
		res.frame_done   = 1'b0;
		res.crc_ok       = 1'b0;
		res.frame_length = 16'd0;
		case (step_q)
			sfr_pkg::STEP_HUNT: begin
				if (rx_byte == cfg.start_byte) begin
					res.stored = 1'b1;
					crc_d      = crc_new;
					len_d      = 16'd0;
					idx_d      = 16'd1;
					step_d     = sfr_pkg::STEP_LEN_LO;
				end else begin
					idx_d = 16'd0;
				end
			end
			sfr_pkg::STEP_LEN_LO: begin
				len_d            = {8'd0, rx_byte};
				res.stored       = 1'b1;
				res.position     = idx_q;
				res.frame_length = {8'd0, rx_byte};
				crc_d            = crc_new;
				idx_d            = idx_inc;
				step_d           = sfr_pkg::STEP_LEN_HI;
			end
			sfr_pkg::STEP_LEN_HI: begin
				len_d            = len_full;
				res.stored       = 1'b1;
				res.position     = idx_q;
				res.frame_length = len_full;
				crc_d            = crc_new;
				if (len_full < cfg.max_frame_len) begin
					idx_d  = idx_inc;
					step_d = sfr_pkg::STEP_DATA;
				end else begin
					idx_d  = 16'd0;
					step_d = sfr_pkg::STEP_HUNT;
				end
			end
			sfr_pkg::STEP_DATA: begin
				res.frame_length = len_q;
				if (idx_q < len_q) begin
					// Keep the byte; finish when the count reaches the length
					res.stored   = 1'b1;
					res.position = idx_q;
					crc_d        = crc_new;
					idx_d        = idx_inc;
					if (idx_inc == len_q) begin
						res.frame_done = 1'b1;
						res.crc_ok     = (crc_new == 32'd0);
						idx_d          = 16'd0;
						step_d         = sfr_pkg::STEP_HUNT;
					end
				end else if (idx_q > len_q) begin
					// Length shorter than the header: drop, unless it is zero
					idx_d  = 16'd0;
					step_d = sfr_pkg::STEP_HUNT;
					if (len_q == 16'd0) begin
						res.frame_done = 1'b1;
						res.crc_ok     = (cfg.crc_start == 32'd0);
					end
				end else begin
					// Length equals the header: check the header bytes
					res.frame_done = 1'b1;
					res.crc_ok     = (crc_q == 32'd0);
					idx_d          = 16'd0;
					step_d         = sfr_pkg::STEP_HUNT;
				end
			end
			default: ;
		endcase
	end

	`ASSERT_IMPLIES(a_done_in_data, clk, arst_n, advance && res.frame_done, step_q == sfr_pkg::STEP_DATA, "frame completed outside the data step")
	`ASSERT_NEXT(a_done_to_hunt, clk, arst_n, advance && res.frame_done, step_q == sfr_pkg::STEP_HUNT && idx_q == 16'd0, "parser did not return to hunt after a frame")
	`ASSERT_IMPLIES(a_ok_needs_done, clk, arst_n, res.crc_ok, res.frame_done, "crc_ok without a completed frame")
	`ASSERT_IMPLIES(a_hunt_idx_zero, clk, arst_n, step_q == sfr_pkg::STEP_HUNT, idx_q == 16'd0, "byte count not cleared while hunting")
	`ASSERT_IMPLIES(a_data_idx_min, clk, arst_n, step_q == sfr_pkg::STEP_DATA, idx_q >= 16'd3, "data step entered before the header was kept")

endmodule

@@ hw/rtl/serial_frame_receiver_crc32.sv @@
// ----------------------------------------------------------------------------
// serial_frame_receiver_crc32
// Serial byte deframer with start-byte hunt, length field and CRC-32 check.
// ----------------------------------------------------------------------------
// The block takes received bytes and returns one result per byte: an input
// register captures the byte, the parser and its one-byte CRC update decide
// the result combinationally, and a result register presents it. Throughput
// is one byte per cycle while the result side is not stalled; a stall on the
// result side holds the result and stalls the input only when the input
// register is also full. Configuration writes are always ready and take
// effect on the next byte that is parsed.

module serial_frame_receiver_crc32 (
	input  logic                           clk,
	input  logic                           arst_n,
	// Received byte channel
	input  logic                           rx_valid,
	output logic                           rx_stall,
	input  logic [7:0]                     rx_byte,
	// Result channel
	output logic                           res_valid,
	input  logic                           res_stall,
	output logic [7:0]                     byte_value,
	output logic                           stored,
	output logic [15:0]                    position,
	output logic                           frame_done,
	output logic                           crc_ok,
	output logic [15:0]                    frame_length,
	// Configuration write channel
	input  logic                           cfg_valid,
	output logic                           cfg_ready,
	input  logic [sfr_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  logic [sfr_pkg::CFG_DATA_W-1:0] cfg_data
);

	sfr_pkg::cfg_t    cfg;
	sfr_pkg::result_t res_comb;
	sfr_pkg::result_t res_q;

	logic       valid_s1;
	logic [7:0] byte_s1;
	logic       res_valid_q;
	logic       advance;

	assign cfg_ready = 1'b1;

	sfr_cfg_regs u_cfg (
		.clk      (clk),
		.arst_n   (arst_n),
		.wr_en    (cfg_valid && cfg_ready),
		.wr_index (cfg_index),
		.wr_data  (cfg_data),
		.cfg      (cfg)
	);

	// Move the captured byte on when the result register is free
	assign advance  = valid_s1 && (!res_valid_q || !res_stall);
	assign rx_stall = valid_s1 && !advance;

	// Capture the incoming transaction
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (!rx_stall) begin
			valid_s1 <= rx_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (rx_valid && !rx_stall) begin
			byte_s1 <= rx_byte;
		end
	end

	sfr_parser u_parser (
		.clk     (clk),
		.arst_n  (arst_n),
		.advance (advance),
		.rx_byte (byte_s1),
		.cfg     (cfg),
		.res     (res_comb)
	);

	// Hold the result until it is taken
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_valid_q <= 1'b0;
		end else if (advance) begin
			res_valid_q <= 1'b1;
		end else if (!res_stall) begin
			res_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			res_q <= res_comb;
		end
	end

	assign res_valid    = res_valid_q;
	assign byte_value   = res_q.byte_value;
	assign stored       = res_q.stored;
	assign position     = res_q.position;
	assign frame_done   = res_q.frame_done;
	assign crc_ok       = res_q.crc_ok;
	assign frame_length = res_q.frame_length;

endmodule

@@ tb/serial_frame_receiver_crc32_test.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// serial_frame_receiver_crc32_test
// Self-checking bench for the serial deframer with length field and CRC-32.
// A short table of hand-picked bytes covers the hunt, the length corner cases
// and the oversize drop. Random frames then follow, with good and bad CRC,
// truncation and line noise. Several register settings and idle patterns
// are used. Each result transaction is compared with its table row where one is
// given, else with a behavioral parser kept in step with the bytes accepted.
// ----------------------------------------------------------------------------
module serial_frame_receiver_crc32_test;

	localparam int CYCLE_LIMIT    = 200000;
	localparam int HOLDOFF_CYCLES = 150;
	localparam int PIPE_CYCLES    = 4;
	localparam int DRAIN_CYCLES   = 12;
	localparam int PHASE_ITEMS    = 78;
	localparam int NUM_PHASES     = 6;
	localparam logic [sfr_pkg::CFG_IDX_W-1:0] CFG_NO_REG = 8'hFF;

	typedef struct {
		logic [7:0]       rx;
		bit               typed;
		sfr_pkg::result_t want;
	} stim_row_t;

	typedef struct {
		logic [7:0]  start_byte;
		logic [15:0] max_len;
		logic [31:0] poly;
		logic [31:0] init;
		int          idle_pct;
		int          stall_pct;
		bit          holdoff;
	} phase_t;

	logic                           clk;
	logic                           arst_n       = 1'b0;
	logic                           rx_valid     = 1'b0;
	logic                           rx_stall;
	logic [7:0]                     rx_byte      = '0;
	logic                           res_valid;
	logic                           res_stall    = 1'b0;
	logic [7:0]                     byte_value;
	logic                           stored;
	logic [15:0]                    position;
	logic                           frame_done;
	logic                           crc_ok;
	logic [15:0]                    frame_length;
	logic                           cfg_valid    = 1'b0;
	logic                           cfg_ready;
	logic [sfr_pkg::CFG_IDX_W-1:0]  cfg_index    = '0;
	logic [sfr_pkg::CFG_DATA_W-1:0] cfg_data     = '0;

	// Parser model state and its copy of the registers
	sfr_pkg::step_t rx_step    = sfr_pkg::STEP_HUNT;
	logic [15:0]    len_decl   = '0;
	logic [15:0]    kept_count = '0;
	logic [31:0]    crc_acc    = sfr_pkg::CRC_START_RST;
	sfr_pkg::cfg_t  live_cfg   = '{sfr_pkg::START_BYTE_RST, sfr_pkg::MAX_LEN_RST,
		sfr_pkg::CRC_POLY_RST, sfr_pkg::CRC_START_RST};

	sfr_pkg::result_t pending_results[$];
	int      mismatch_count  = 0;
	int      results_seen    = 0;
	int      cycle_count     = 0;
	int      sender_idle_pct = 0;
	int      stall_pct       = 0;
	logic    holding         = 1'b0;
	bit      holdoff_fired   = 1'b0;
	event    holdoff_go;

	// Hand-picked bytes, run with the reset register values
	stim_row_t directed_rows[25] = '{
		'{8'h00, 1'b1, '{8'h00, 1'b0, 16'd0, 1'b0, 1'b0, 16'd0}},
		'{8'hFF, 1'b1, '{8'hFF, 1'b0, 16'd0, 1'b0, 1'b0, 16'd0}},
		// declared length 3: closes on the first byte after the header
		'{8'hA5, 1'b1, '{8'hA5, 1'b1, 16'd0, 1'b0, 1'b0, 16'd0}},
		'{8'h03, 1'b1, '{8'h03, 1'b1, 16'd1, 1'b0, 1'b0, 16'd3}},
		'{8'h00, 1'b1, '{8'h00, 1'b1, 16'd2, 1'b0, 1'b0, 16'd3}},
		'{8'h77, 1'b0, '0},
		// declared length 0: residue is the start value, so never good here
		'{8'hA5, 1'b1, '{8'hA5, 1'b1, 16'd0, 1'b0, 1'b0, 16'd0}},
		'{8'h00, 1'b1, '{8'h00, 1'b1, 16'd1, 1'b0, 1'b0, 16'd0}},
		'{8'h00, 1'b1, '{8'h00, 1'b1, 16'd2, 1'b0, 1'b0, 16'd0}},
		'{8'h12, 1'b1, '{8'h12, 1'b0, 16'd0, 1'b1, 1'b0, 16'd0}},
		// declared length 1: back to hunting without a check
		'{8'hA5, 1'b1, '{8'hA5, 1'b1, 16'd0, 1'b0, 1'b0, 16'd0}},
		'{8'h01, 1'b1, '{8'h01, 1'b1, 16'd1, 1'b0, 1'b0, 16'd1}},
		'{8'h00, 1'b1, '{8'h00, 1'b1, 16'd2, 1'b0, 1'b0, 16'd1}},
		'{8'h34, 1'b1, '{8'h34, 1'b0, 16'd0, 1'b0, 1'b0, 16'd1}},
		// length equal to the maximum: drop after the second length byte
		'{8'hA5, 1'b1, '{8'hA5, 1'b1, 16'd0, 1'b0, 1'b0, 16'd0}},
		'{8'h00, 1'b1, '{8'h00, 1'b1, 16'd1, 1'b0, 1'b0, 16'd0}},
		'{8'h04, 1'b1, '{8'h04, 1'b1, 16'd2, 1'b0, 1'b0, 16'h0400}},
		// largest length field
		'{8'hA5, 1'b1, '{8'hA5, 1'b1, 16'd0, 1'b0, 1'b0, 16'd0}},
		'{8'hFF, 1'b1, '{8'hFF, 1'b1, 16'd1, 1'b0, 1'b0, 16'h00FF}},
		'{8'hFF, 1'b1, '{8'hFF, 1'b1, 16'd2, 1'b0, 1'b0, 16'hFFFF}},
		// short frame with two data bytes
		'{8'hA5, 1'b1, '{8'hA5, 1'b1, 16'd0, 1'b0, 1'b0, 16'd0}},
		'{8'h05, 1'b1, '{8'h05, 1'b1, 16'd1, 1'b0, 1'b0, 16'd5}},
		'{8'h00, 1'b1, '{8'h00, 1'b1, 16'd2, 1'b0, 1'b0, 16'd5}},
		'{8'h5A, 1'b1, '{8'h5A, 1'b1, 16'd3, 1'b0, 1'b0, 16'd5}},
		'{8'hC3, 1'b0, '0}
	};

	phase_t phases[NUM_PHASES];

	serial_frame_receiver_crc32 u_top (
		.clk          (clk),
		.arst_n       (arst_n),
		.rx_valid     (rx_valid),
		.rx_stall     (rx_stall),
		.rx_byte      (rx_byte),
		.res_valid    (res_valid),
		.res_stall    (res_stall),
		.byte_value   (byte_value),
		.stored       (stored),
		.position     (position),
		.frame_done   (frame_done),
		.crc_ok       (crc_ok),
		.frame_length (frame_length),
		.cfg_valid    (cfg_valid),
		.cfg_ready    (cfg_ready),
		.cfg_index    (cfg_index),
		.cfg_data     (cfg_data)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	// Abort a hung run
	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count > CYCLE_LIMIT) begin
			$display("== FAIL ==");
			$finish;
		end
	end

	// Randomly stall the result side; hold it off for a long stretch on request
	always @(posedge clk) begin
		res_stall <= holding || ($urandom_range(99) < stall_pct);
	end

	initial begin : result_holdoff
		@(holdoff_go);
		@(posedge clk);
		holding <= 1'b1;
		repeat (HOLDOFF_CYCLES) @(posedge clk);
		holding <= 1'b0;
	end

	// One reflected CRC-32 byte step with the given polynomial
	function automatic logic [31:0] crc32_step(input logic [31:0] crc, input logic [7:0] b,
			input logic [31:0] poly);
		logic [31:0] t;
		int k;
		t = {24'd0, crc[7:0] ^ b};
		for (k = 0; k < 8; k++)
			t = t[0] ? ((t >> 1) ^ poly) : (t >> 1);
		return (crc >> 8) ^ t;
	endfunction

	// Advance the parser model by one byte and return its result
	function automatic sfr_pkg::result_t parse_byte(input logic [7:0] b);
		sfr_pkg::result_t r;
		logic [31:0] residue;
		bit restarted;
		r = '0;
		r.byte_value = b;
		restarted = 1'b0;
		case (rx_step)
			sfr_pkg::STEP_HUNT: begin
				if (b == live_cfg.start_byte) begin
					r.stored = 1'b1;
					crc_acc = crc32_step(live_cfg.crc_start, b, live_cfg.crc_poly);
					len_decl = '0;
					kept_count = 16'd1;
					rx_step = sfr_pkg::STEP_LEN_LO;
				end else begin
					kept_count = '0;
				end
			end
			sfr_pkg::STEP_LEN_LO: begin
				len_decl = {8'd0, b};
				r.stored = 1'b1;
				r.position = kept_count;
				crc_acc = crc32_step(crc_acc, b, live_cfg.crc_poly);
				kept_count = kept_count + 16'd1;
				rx_step = sfr_pkg::STEP_LEN_HI;
				r.frame_length = len_decl;
			end
			sfr_pkg::STEP_LEN_HI: begin
				len_decl = {b, len_decl[7:0]};
				r.stored = 1'b1;
				r.position = kept_count;
				crc_acc = crc32_step(crc_acc, b, live_cfg.crc_poly);
				kept_count = kept_count + 16'd1;
				r.frame_length = len_decl;
				if (len_decl < live_cfg.max_frame_len) begin
					rx_step = sfr_pkg::STEP_DATA;
				end else begin
					rx_step = sfr_pkg::STEP_HUNT;
					kept_count = '0;
				end
			end
			default: begin
				r.frame_length = len_decl;
				if (kept_count < len_decl) begin
					r.stored = 1'b1;
					r.position = kept_count;
					crc_acc = crc32_step(crc_acc, b, live_cfg.crc_poly);
					kept_count = kept_count + 16'd1;
				end else if (kept_count > len_decl) begin
					// header overran a tiny declared length: restart the hunt
					rx_step = sfr_pkg::STEP_HUNT;
					kept_count = '0;
					restarted = 1'b1;
				end
				if (kept_count == len_decl) begin
					residue = restarted ? live_cfg.crc_start : crc_acc;
					r.frame_done = 1'b1;
					r.crc_ok = (residue == 32'd0);
					rx_step = sfr_pkg::STEP_HUNT;
					kept_count = '0;
				end
			end
		endcase
		return r;
	endfunction

	task automatic report_mismatch(input string what, input logic [31:0] got,
			input logic [31:0] want);
		$display("mismatch at result %0d: %s got 0x%0h, want 0x%0h",
			results_seen, what, got, want);
		mismatch_count++;
	endtask

	task automatic check_field(input string what, input logic [31:0] got,
			input logic [31:0] want);
		if (got !== want)
			report_mismatch(what, got, want);
	endtask

	// Compare each result transaction with the oldest pending one
	always @(negedge clk) begin : result_check
		sfr_pkg::result_t want;
		if (arst_n && res_valid && !res_stall) begin
			if (pending_results.size() == 0) begin
				report_mismatch("unexpected result, byte_value", 32'(byte_value), 32'd0);
			end else begin
				want = pending_results.pop_front();
				check_field("byte_value", 32'(byte_value), 32'(want.byte_value));
				check_field("stored", 32'(stored), 32'(want.stored));
				check_field("position", 32'(position), 32'(want.position));
				check_field("frame_done", 32'(frame_done), 32'(want.frame_done));
				check_field("crc_ok", 32'(crc_ok), 32'(want.crc_ok));
				check_field("frame_length", 32'(frame_length), 32'(want.frame_length));
			end
			results_seen++;
		end
	end

	// Offer one byte, idling first at random; leave valid high after the transaction
	task automatic send_byte(input logic [7:0] b, input bit typed,
			input sfr_pkg::result_t want);
		sfr_pkg::result_t predicted;
		while ($urandom_range(99) < sender_idle_pct) begin
			rx_valid <= 1'b0;
			@(posedge clk);
		end
		rx_valid <= 1'b1;
		rx_byte <= b;
		@(negedge clk);
		while (rx_stall) @(negedge clk);
		predicted = parse_byte(b);
		pending_results.push_back(typed ? want : predicted);
		@(posedge clk);
	endtask

	// Write one register; the caller lowers valid after the last write
	task automatic write_reg(input logic [sfr_pkg::CFG_IDX_W-1:0] idx,
			input logic [31:0] data);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data <= data;
		@(negedge clk);
		while (!cfg_ready) @(negedge clk);
		@(posedge clk);
		case (idx)
			sfr_pkg::CFG_START_BYTE: live_cfg.start_byte = data[7:0];
			sfr_pkg::CFG_MAX_LEN:    live_cfg.max_frame_len = data[15:0];
			sfr_pkg::CFG_CRC_POLY:   live_cfg.crc_poly = data;
			sfr_pkg::CFG_CRC_START:  live_cfg.crc_start = data;
			default: ;
		endcase
	endtask

	// Send line noise or one frame: tiny, oversize, truncated, good or bad CRC
	task automatic send_frame(inout int sent);
		int kind;
		int len;
		int body;
		int cut;
		int i;
		bit crc_good;
		logic [31:0] crc;
		logic [31:0] tail;
		logic [7:0] b;
		kind = $urandom_range(99);
		if (kind < 12) begin
			repeat ($urandom_range(3, 1)) begin
				send_byte(8'($urandom_range(255)), 1'b0, '0);
				sent++;
			end
			return;
		end
		if (kind < 20)
			len = $urandom_range(3, 0);
		else if (kind < 28)
			len = $urandom_range(65535, live_cfg.max_frame_len);
		else
			len = $urandom_range(24, 4);
		crc = crc32_step(live_cfg.crc_start, live_cfg.start_byte, live_cfg.crc_poly);
		crc = crc32_step(crc, len[7:0], live_cfg.crc_poly);
		crc = crc32_step(crc, len[15:8], live_cfg.crc_poly);
		send_byte(live_cfg.start_byte, 1'b0, '0);
		send_byte(len[7:0], 1'b0, '0);
		send_byte(len[15:8], 1'b0, '0);
		sent += 3;
		if (len >= live_cfg.max_frame_len)
			return;
		if (len < 4) begin
			send_byte(8'($urandom_range(255)), 1'b0, '0);
			sent++;
			return;
		end
		body = len - 3;
		cut = ($urandom_range(99) < 10) ? $urandom_range(body - 1, 0) : body;
		crc_good = (len >= 7) && ($urandom_range(1) == 1);
		tail = '0;
		for (i = 0; i < cut; i++) begin
			// append the running CRC low byte first so the residue ends at zero
			if (crc_good && i == body - 4)
				tail = crc;
			if (crc_good && i >= body - 4)
				b = tail[8 * (i - body + 4) +: 8];
			else
				b = 8'($urandom_range(255));
			crc = crc32_step(crc, b, live_cfg.crc_poly);
			send_byte(b, 1'b0, '0);
			sent++;
		end
	endtask

	initial begin : stimulus
		int ph;
		int sent;
		phases[0] = '{sfr_pkg::START_BYTE_RST, sfr_pkg::MAX_LEN_RST, sfr_pkg::CRC_POLY_RST,
			sfr_pkg::CRC_START_RST, 0, 0, 1'b0};
		phases[1] = '{8'h00, 16'hFFFF, 32'h82F6_3B78, 32'h0000_0000, 82, 0, 1'b0};
		phases[2] = '{8'hFF, 16'd1, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 0, 82, 1'b0};
		phases[3] = '{8'($urandom_range(255)), 16'd30, 32'h0000_0000, $urandom,
			18, 18, 1'b0};
		phases[4] = '{8'($urandom_range(255)), 16'($urandom_range(64, 8)), $urandom,
			$urandom, 0, 0, 1'b1};
		phases[5] = '{sfr_pkg::START_BYTE_RST, sfr_pkg::MAX_LEN_RST, sfr_pkg::CRC_POLY_RST,
			sfr_pkg::CRC_START_RST, 18, 18, 1'b0};

		// Hold reset, then release on a clock edge
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		foreach (directed_rows[i])
			send_byte(directed_rows[i].rx, directed_rows[i].typed, directed_rows[i].want);

		for (ph = 0; ph < NUM_PHASES; ph++) begin
			if (ph != 0) begin
				// Drain everything in flight before touching the registers
				rx_valid <= 1'b0;
				while (pending_results.size() != 0) @(posedge clk);
				repeat (PIPE_CYCLES) @(posedge clk);
				write_reg(sfr_pkg::CFG_START_BYTE, {24'd0, phases[ph].start_byte});
				write_reg(sfr_pkg::CFG_MAX_LEN, {16'd0, phases[ph].max_len});
				write_reg(sfr_pkg::CFG_CRC_POLY, phases[ph].poly);
				write_reg(sfr_pkg::CFG_CRC_START, phases[ph].init);
				if (ph == 2) begin
					// indexes past the register list must be ignored
					write_reg(sfr_pkg::CFG_CRC_START + 8'd1, $urandom);
					write_reg(CFG_NO_REG, $urandom);
				end
				cfg_valid <= 1'b0;
			end
			sender_idle_pct = phases[ph].idle_pct;
			stall_pct <= phases[ph].stall_pct;
			sent = 0;
			while (sent < PHASE_ITEMS) begin
				// start the long receiver hold-off once, mid-phase
				if (phases[ph].holdoff && sent >= 30 && !holdoff_fired) begin
					holdoff_fired = 1'b1;
					-> holdoff_go;
				end
				send_frame(sent);
			end
		end

		// Wait out the last results
		rx_valid <= 1'b0;
		while (pending_results.size() != 0) @(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (mismatch_count == 0) begin
			$display("== PASS ==");
		end else begin
			$display("== FAIL ==");
		end
		$finish;
	end

endmodule

@@ files.f @@
+incdir+hw/rtl
hw/rtl/sfr_pkg.sv
hw/rtl/sfr_cfg_regs.sv
hw/rtl/sfr_crc_byte.sv
hw/rtl/sfr_parser.sv
hw/rtl/serial_frame_receiver_crc32.sv
tb/serial_frame_receiver_crc32_test.sv
